// ----- rtl/tnis_pkg.sv -----
// ----------------------------------------------------------------------------
// tnis_pkg
// Shared types and constants for the top-n index selector: the input and
// result transaction structs and the fixed field widths.
// ----------------------------------------------------------------------------
package tnis_pkg;

	// Field widths fixed by the interface
	localparam int VALUE_W     = 32;
	localparam int INDEX_W     = 8;
	localparam int TOP_COUNT_W = 5;

	// Reset value of the top_count register
	localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET = 5'd1;

	// Flip the sign bit so that unsigned order equals signed order
	localparam logic [VALUE_W-1:0] SIGN_FLIP = 32'h8000_0000;

	// One input transaction
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last_in;
	} item_t;

	// One result transaction
	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               last_out;
	} result_t;

endpackage

// ----- rtl/top_n_index_select_top.sv -----
// ----------------------------------------------------------------------------
// top_n_index_select_top
// Loads a set of signed Q16.16 values into a RAM, one per transaction. The
// transaction flagged last closes the set; the block then returns the indices
// of the top_count largest values (at most MAX_TOP) in descending order, earlier
// index first on ties, flagging the final one.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload               | direction
//  --------+------------------------+-----------------------+----------
//  item    | item_valid / item_stall| item (value, last_in) | in
//  result  | result_valid / stall   | result (index, last)  | out
//  cfg     | cfg_valid / cfg_ready  | cfg_data (top_count)  | in
//
//  Loading takes one item per cycle while item_stall is low; each item is written
//  straight to the RAM while it has room, and later items are dropped. Selection:
//  each pick scans the loaded entries through the RAM read port and hands its
//  result to the output register. item_stall is high from the closing item until
//  the final result is in the output register. Reset clears all control state;
//  the RAM needs no clearing, since only entries of the current set are ever read.
// ----------------------------------------------------------------------------
module top_n_index_select_top #(
	parameter int MAX_ITEMS = 256,
	parameter int MAX_TOP   = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  tnis_pkg::item_t                      item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output tnis_pkg::result_t                    result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tnis_pkg::TOP_COUNT_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = AW + 1;
	localparam int PW = $clog2(MAX_TOP + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;

	logic [tnis_pkg::TOP_COUNT_W-1:0] top_count_q;
	logic [CW-1:0]                    load_count_q;
	logic [CW-1:0]                    scan_ptr_q;
	logic [PW-1:0]                    picks_q;
	logic [PW-1:0]                    pick_q;
	logic [PW-1:0]                    picks_sat;

	logic                             rd_v_s1;
	logic [AW-1:0]                    rd_idx_s1;
	logic [tnis_pkg::VALUE_W-1:0]     rd_data;

	logic                             found_q;
	logic [tnis_pkg::VALUE_W-1:0]     best_key_q;
	logic [AW-1:0]                    best_idx_q;
	logic                             have_prev_q;
	logic [tnis_pkg::VALUE_W-1:0]     prev_key_q;
	logic [AW-1:0]                    prev_idx_q;

	logic                             result_valid_q;
	tnis_pkg::result_t                result_q;

	logic                             item_acc;
	logic                             store_free;
	logic                             wr_en;
	logic                             rd_issue;
	logic                             scan_done;
	logic                             out_load;
	logic                             final_pick;
	logic [tnis_pkg::VALUE_W-1:0]     cand_key;
	logic                             eligible;
	logic                             better;

	// Handshake decode
	assign item_acc   = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign store_free = (load_count_q < CW'(MAX_ITEMS));
	assign wr_en      = item_acc && store_free;

	// Saturate the requested count to the largest supported run
	always_comb begin
		if (32'(top_count_q) > 32'(MAX_TOP)) begin
			picks_sat = PW'(MAX_TOP);
		end else begin
			picks_sat = PW'(top_count_q);
		end
	end

	// Value store
	tnis_ram #(
		.WIDTH(tnis_pkg::VALUE_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(load_count_q[AW-1:0]),
		.wr_data(item.value),
		.rd_en  (rd_issue),
		.rd_addr(scan_ptr_q[AW-1:0]),
		.rd_data(rd_data)
	);

	// Scan control: issue one read per cycle, finish once the last read returns
	assign rd_issue  = (state_q == ST_SCAN) && (scan_ptr_q != load_count_q);
	assign scan_done = (state_q == ST_SCAN) && (scan_ptr_q == load_count_q) && !rd_v_s1;

	// Candidate test: below the previous pick in (key desc, index asc) order,
	// and strictly greater than the current best
	assign cand_key = rd_data ^ tnis_pkg::SIGN_FLIP;
	assign eligible = !have_prev_q || (cand_key < prev_key_q) ||
	                  ((cand_key == prev_key_q) && (rd_idx_s1 > prev_idx_q));
	assign better   = !found_q || (cand_key > best_key_q);

	// Output handover
	assign out_load   = (state_q == ST_EMIT) && (!result_valid_q || !result_stall);
	assign final_pick = ({1'b0, pick_q} + 1'b1) == {1'b0, picks_q};

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= tnis_pkg::TOP_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			top_count_q <= cfg_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			load_count_q <= '0;
			scan_ptr_q   <= '0;
			picks_q      <= '0;
			pick_q       <= '0;
			rd_v_s1      <= 1'b0;
			found_q      <= 1'b0;
			have_prev_q  <= 1'b0;
		end else begin
			rd_v_s1 <= rd_issue;
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (item.last_in) begin
							if (picks_sat == '0) begin
								// Close the set without results
								load_count_q <= '0;
							end else begin
								if (store_free) begin
									load_count_q <= load_count_q + 1'b1;
								end
								picks_q     <= picks_sat;
								pick_q      <= '0;
								scan_ptr_q  <= '0;
								found_q     <= 1'b0;
								have_prev_q <= 1'b0;
								state_q     <= ST_SCAN;
							end
						end else if (store_free) begin
							load_count_q <= load_count_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (rd_issue) begin
						scan_ptr_q <= scan_ptr_q + 1'b1;
					end
					if (rd_v_s1 && eligible && better) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						// Advance the threshold to this pick
						if (found_q) begin
							have_prev_q <= 1'b1;
						end
						found_q    <= 1'b0;
						scan_ptr_q <= '0;
						pick_q     <= pick_q + 1'b1;
						if (final_pick) begin
							load_count_q <= '0;
							state_q      <= ST_IDLE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pipeline stage 1 index and best/previous payload
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_ptr_q[AW-1:0];
		if ((state_q == ST_SCAN) && rd_v_s1 && eligible && better) begin
			best_key_q <= cand_key;
			best_idx_q <= rd_idx_s1;
		end
		if (out_load && found_q) begin
			prev_key_q <= best_key_q;
			prev_idx_q <= best_idx_q;
		end
	end

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.index    <= found_q ? tnis_pkg::INDEX_W'(best_idx_q) : '0;
			result_q.last_out <= final_pick;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/tnis_ram.sv -----
// ----------------------------------------------------------------------------
// tnis_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tnis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/tnis_checker.sv -----
// ----------------------------------------------------------------------------
// tnis_checker
// Port-level checks for the top-n index selector, bound to the top level.
// ----------------------------------------------------------------------------
module tnis_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  logic                             item_stall,
	input  tnis_pkg::item_t                  item,
	input  logic                             result_valid,
	input  logic                             result_stall,
	input  tnis_pkg::result_t                result,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [tnis_pkg::TOP_COUNT_W-1:0] cfg_data
);

	logic item_acc;

	assign item_acc = item_valid && !item_stall;

	// Hold a stalled result transaction
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result transaction changed");

	// Drop nothing new after a non-closing item when the output was empty
	a_no_result_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && !item.last_in && !result_valid) |=> !result_valid)
		else $error("result appeared after a non-closing item");

	// Keep input stalled while a result before the final one is on offer
	a_stall_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last_out) |-> item_stall)
		else $error("input accepted in the middle of a run");

	// Offer only fully defined result transactions
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !$isunknown(result))
		else $error("result transaction carries unknown bits");

	// Configuration writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> (cfg_ready && !$isunknown(cfg_data)))
		else $error("configuration write refused");

endmodule

bind top_n_index_select_top tnis_checker u_tnis_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.item        (item),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready),
	.cfg_data    (cfg_data)
);
